// File: src/sgb_pkg.sv
// Shared types and constants of the 5x5 separable Gaussian blur.
// No dependencies; sgb_lane, sgb_front and the top level import this package.
package sgb_pkg;

  // Field and counter widths
  localparam int CFG_W         = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int ROW_W         = 12;
  localparam int CH_W          = 8;
  localparam int NUM_CH        = 3;
  localparam int PIX_W         = CH_W * NUM_CH;
  localparam int SLOT_W        = 2;
  localparam int NUM_SLOTS     = 4;
  localparam int TAP_COUNT     = 5;
  localparam int HALF          = TAP_COUNT / 2;
  localparam int DEF_MAX_WIDTH = 2048;

  // Divide-by-ten: sum * 3277 >> 15 is exact for sums below 16384
  localparam int SUM_W     = 12;
  localparam int PROD_W    = 24;
  localparam int DIV_SHIFT = 15;
  localparam logic [SUM_W-1:0] DIV_RECIP = 12'd3277;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0]     RST_FRAME_HEIGHT = 12'd480;

  typedef struct packed {
    logic             mode;
    logic [CH_W-1:0]  in_blue;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_red;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_blue;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_red;
    logic             frame_end;
  } out_item_t;

  // Control of one column job travelling down the pipeline
  typedef struct packed {
    logic              emit;     // produces an output pixel
    logic              wr;       // writes its horizontal value to the line store
    logic              vf;       // output is vertically filtered
    logic              hf;       // horizontal value comes from the filter lane
    logic              fin;      // last pixel of the frame
    logic [SLOT_W-1:0] base;     // line store slot of the job's input row
    logic [SLOT_W-1:0] rd_slot;  // slot read when the output is not filtered
  } job_ctl_t;

endpackage

// File: src/sgb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; read during write of the same address returns old data.
module sgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/sgb_lane.sv
// One channel lane of the 1 2 4 2 1 filter: weighted sum, then divide by ten.
// Depends on sgb_pkg. Sum is registered; the quotient follows it combinationally.
module sgb_lane import sgb_pkg::*; (
  input  logic                             clk,
  input  logic                             en,
  input  logic [TAP_COUNT-1:0][CH_W-1:0]   tap,
  output logic [CH_W-1:0]                  q
);

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [PROD_W-1:0] prod;

  // Weighted sum of the five taps
  always_comb begin
    sum_nxt = SUM_W'(tap[0]) + (SUM_W'(tap[1]) << 1) + (SUM_W'(tap[2]) << 2)
            + (SUM_W'(tap[3]) << 1) + SUM_W'(tap[4]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // Truncating divide by ten through the reciprocal
  assign prod = PROD_W'(sum_r) * PROD_W'(DIV_RECIP);
  assign q    = prod[DIV_SHIFT +: CH_W];

endmodule

// File: src/sgb_front.sv
// Front end: configuration registers, raster counters, raw pixel window,
// column job issue and horizontal filter lanes. Depends on sgb_pkg, sgb_lane.
module sgb_front import sgb_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  b_open,
  output logic                  a_vld,
  output job_ctl_t              a_ctl,
  output logic [COL_W-1:0]      a_col,
  output logic [PIX_W-1:0]      a_t
);

  localparam int CW1  = COL_W + 1;
  localparam int CMPW = (CW1 > CFG_W) ? CW1 : CFG_W;
  localparam logic [CMPW-1:0] WMAX = CMPW'(MAX_WIDTH);

  logic [CFG_W-1:0]            cfg_w_r, cfg_w_nxt, cfg_h_r, cfg_h_nxt;
  logic [ROW_W-1:0]            in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [ROW_W-1:0]            pend_row_r, pend_row_nxt;
  logic [COL_W-1:0]            in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [COL_W-1:0]            pend_col_r, pend_col_nxt;
  logic [1:0]                  pend_cnt_r, pend_cnt_nxt;
  logic [3:0][PIX_W-1:0]       rw_r, rw_nxt;
  logic                        a_vld_r;
  job_ctl_t                    a_ctl_r;
  logic [COL_W-1:0]            a_col_r;
  logic [PIX_W-1:0]            a_traw_r;

  logic [CMPW-1:0]             w_cfg_x;
  logic [CW1-1:0]              w_eff, w_m1;
  logic [CFG_W-1:0]            h_eff;
  logic                        a_open, acc, pix_acc, fls_acc, frame_done;
  logic [COL_W-1:0]            ic, lo;
  logic [ROW_W-1:0]            ir;
  logic                        last, ic_ge, pix_job, first_hf;
  logic [1:0]                  npend;
  logic [PIX_W-1:0]            cur, first_t, pend_t;
  logic                        issue, is_flush;
  logic [ROW_W-1:0]            j_row, adv_row;
  logic [COL_W-1:0]            j_col, adv_col;
  logic [CW1-1:0]              adv_col1, ic1;
  logic [PIX_W-1:0]            j_t;
  job_ctl_t                    jc;
  logic [PIX_W-1:0]            hq;

  // Effective frame size: width clamped to 1..MAX_WIDTH, height zero read as one
  assign w_cfg_x = CMPW'(cfg_w_r);
  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = CW1'(1);
    end else if (w_cfg_x > WMAX) begin
      w_eff = CW1'(WMAX);
    end else begin
      w_eff = CW1'(w_cfg_x);
    end
  end
  assign w_m1  = w_eff - CW1'(1);
  assign h_eff = (cfg_h_r == '0) ? CFG_W'(1) : cfg_h_r;

  // Handshake: row-end jobs still pending hold the input off
  assign a_open     = !a_vld_r || b_open;
  assign in_ready   = a_open && (pend_cnt_r == '0);
  assign acc        = in_valid && in_ready;
  assign pix_acc    = acc && !in_data.mode;
  assign fls_acc    = acc && in_data.mode;
  assign frame_done = in_row_r >= ROW_W'(h_eff);

  // Position of the arriving pixel; a pixel after a complete frame starts a new one
  assign ic  = frame_done ? '0 : in_col_r;
  assign ir  = frame_done ? '0 : in_row_r;
  assign cur = {in_data.in_red, in_data.in_green, in_data.in_blue};

  // Columns made final by this pixel: lo up to ic on the last column, else ic-2
  assign last    = CW1'(ic) == w_m1;
  assign ic_ge   = ic >= COL_W'(HALF);
  assign lo      = ic_ge ? ic - COL_W'(HALF) : '0;
  assign pix_job = last || ic_ge;
  assign npend   = last ? 2'(ic - lo) : 2'd0;
  assign ic1     = CW1'(ic) + CW1'(1);

  always_comb begin
    if (lo == ic) begin
      first_t = cur;
    end else if (lo + COL_W'(1) == ic) begin
      first_t = rw_r[0];
    end else begin
      first_t = rw_r[1];
    end
  end
  assign first_hf = (lo >= COL_W'(HALF)) && (CW1'(lo) + CW1'(HALF) < w_eff);

  // Pending row-end jobs see the window already shifted by one
  assign pend_t = (CW1'(pend_col_r) == w_m1) ? rw_r[0] : rw_r[1];

  // Job selection
  always_comb begin
    issue    = 1'b0;
    is_flush = 1'b0;
    j_row    = ir;
    j_col    = lo;
    j_t      = first_t;
    jc       = '0;
    if (pend_cnt_r != '0 && a_open) begin
      issue  = 1'b1;
      j_row  = pend_row_r;
      j_col  = pend_col_r;
      j_t    = pend_t;
    end else if (pix_acc && pix_job) begin
      issue  = 1'b1;
      jc.hf  = first_hf;
    end else if (fls_acc && frame_done && (out_row_r < ROW_W'(h_eff))) begin
      issue    = 1'b1;
      is_flush = 1'b1;
      j_col    = out_col_r;
    end
    if (is_flush) begin
      jc.emit    = 1'b1;
      jc.rd_slot = out_row_r[SLOT_W-1:0];
      jc.base    = out_row_r[SLOT_W-1:0];
      jc.fin     = (out_row_r == ROW_W'(h_eff - CFG_W'(1))) && (CW1'(out_col_r) == w_m1);
    end else begin
      jc.emit    = j_row >= ROW_W'(HALF);
      jc.wr      = 1'b1;
      jc.vf      = j_row >= ROW_W'(2 * HALF);
      jc.base    = j_row[SLOT_W-1:0];
      jc.rd_slot = j_row[SLOT_W-1:0] - SLOT_W'(HALF);
    end
  end

  // Output position that the issued job leaves behind
  always_comb begin
    adv_row  = is_flush ? out_row_r : j_row - ROW_W'(HALF);
    adv_col  = j_col;
    adv_col1 = CW1'(adv_col) + CW1'(1);
  end

  // Counter, window and pending-job updates
  always_comb begin
    cfg_w_nxt    = cfg_w_r;
    cfg_h_nxt    = cfg_h_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    pend_row_nxt = pend_row_r;
    pend_col_nxt = pend_col_r;
    pend_cnt_nxt = pend_cnt_r;
    rw_nxt       = rw_r;
    if (pend_cnt_r != '0 && a_open) begin
      pend_cnt_nxt = pend_cnt_r - 2'd1;
      pend_col_nxt = pend_col_r + COL_W'(1);
    end
    if (pix_acc) begin
      if (frame_done) begin
        out_row_nxt = '0;
        out_col_nxt = '0;
      end
      if (ic1 >= w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = ir + ROW_W'(1);
      end else begin
        in_col_nxt = ic + COL_W'(1);
        in_row_nxt = ir;
      end
      rw_nxt       = {rw_r[2:0], cur};
      pend_cnt_nxt = npend;
      pend_col_nxt = lo + COL_W'(1);
      pend_row_nxt = ir;
    end
    if (issue && jc.emit) begin
      if (adv_col1 >= w_eff) begin
        out_col_nxt = '0;
        out_row_nxt = adv_row + ROW_W'(1);
      end else begin
        out_col_nxt = COL_W'(adv_col1);
        out_row_nxt = adv_row;
      end
    end
    // A register write abandons the frame in progress
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg_w_nxt = cfg_wdata;
        REG_FRAME_HEIGHT: cfg_h_nxt = cfg_wdata;
        default: ;
      endcase
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      pend_cnt_nxt = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r    <= RST_FRAME_WIDTH;
      cfg_h_r    <= RST_FRAME_HEIGHT;
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      pend_cnt_r <= '0;
      rw_r       <= '0;
      a_vld_r    <= 1'b0;
    end else begin
      cfg_w_r    <= cfg_w_nxt;
      cfg_h_r    <= cfg_h_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      rw_r       <= rw_nxt;
      if (a_open) begin
        a_vld_r <= issue;
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    if (a_open && issue) begin
      a_ctl_r  <= jc;
      a_col_r  <= j_col;
      a_traw_r <= j_t;
    end
  end

  // Horizontal lanes, one per channel, centered two columns back
  for (genvar k = 0; k < NUM_CH; k++) begin : g_hlane
    logic [TAP_COUNT-1:0][CH_W-1:0] htap;
    assign htap = {cur[k*CH_W +: CH_W], rw_r[0][k*CH_W +: CH_W], rw_r[1][k*CH_W +: CH_W],
                   rw_r[2][k*CH_W +: CH_W], rw_r[3][k*CH_W +: CH_W]};
    sgb_lane u_lane (
      .clk (clk),
      .en  (a_open && issue),
      .tap (htap),
      .q   (hq[k*CH_W +: CH_W])
    );
  end

  assign a_vld = a_vld_r;
  assign a_ctl = a_ctl_r;
  assign a_col = a_col_r;
  assign a_t   = a_ctl_r.hf ? hq : a_traw_r;

endmodule

// File: src/separable_gaussian_blur_5x5.sv
// 5x5 separable Gaussian blur, top level. Instantiates sgb_front, sgb_ram, sgb_lane;
// uses types and constants from sgb_pkg.
//
// Takes one raster pixel (or flush tick) per clock unless the output stalls. Each
// column of a row becomes one job that reads all four line stores at that column
// together, so the last pixel of a row, which finishes up to three columns at once,
// holds the input until its extra jobs have issued. Flush ticks drain the last two
// rows at one pixel per tick. Blue, green and red are filtered by three side-by-side
// lanes at each stage. The line stores need no clearing after reset; every read
// whose data is used hits an entry written earlier in the same frame. Register writes
// restart the frame and are expected while the block is idle.
module separable_gaussian_blur_5x5 import sgb_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                              a_vld;
  job_ctl_t                          a_ctl;
  logic [COL_W-1:0]                  a_col;
  logic [PIX_W-1:0]                  a_t;
  logic                              a_move, b_open, b_move, c_open, out_ld;
  logic [NUM_SLOTS-1:0][PIX_W-1:0]   rd_q;

  logic                              b_vld_r, c_vld_r, out_vld_r;
  job_ctl_t                          b_ctl_r, c_ctl_r;
  logic [PIX_W-1:0]                  b_t_r, c_direct_r;
  out_item_t                         out_data_r, out_nxt;
  logic [NUM_CH-1:0][TAP_COUNT-1:0][CH_W-1:0] vtap;
  logic [PIX_W-1:0]                  vq, v;
  logic [SLOT_W-1:0]                 s1, s2, s3;

  // Stall chain: a stage moves when the one after it is empty or moving
  assign out_ld = !out_vld_r || out_ready;
  assign c_open = !c_vld_r || out_ld;
  assign b_open = !b_vld_r || c_open;
  assign b_move = b_vld_r && c_open;
  assign a_move = a_vld && b_open;

  sgb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .b_open    (b_open),
    .a_vld     (a_vld),
    .a_ctl     (a_ctl),
    .a_col     (a_col),
    .a_t       (a_t)
  );

  // Four line stores, one per row slot; a pixel job writes its own row and every job reads all four
  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    sgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk     (clk),
      .wr_en   (a_move && a_ctl.wr && (a_ctl.base == SLOT_W'(s))),
      .wr_addr (a_col),
      .wr_data (a_t),
      .rd_en   (a_move),
      .rd_addr (a_col),
      .rd_data (rd_q[s])
    );
  end

  // Stage B: horizontal value waits beside the line store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_open) begin
      b_vld_r <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_ctl_r <= a_ctl;
      b_t_r   <= a_t;
    end
  end

  // Vertical taps, oldest row first, current row last
  assign s1 = b_ctl_r.base + SLOT_W'(1);
  assign s2 = b_ctl_r.base + SLOT_W'(2);
  assign s3 = b_ctl_r.base + SLOT_W'(3);

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      vtap[k][0] = rd_q[b_ctl_r.base][k*CH_W +: CH_W];
      vtap[k][1] = rd_q[s1][k*CH_W +: CH_W];
      vtap[k][2] = rd_q[s2][k*CH_W +: CH_W];
      vtap[k][3] = rd_q[s3][k*CH_W +: CH_W];
      vtap[k][4] = b_t_r[k*CH_W +: CH_W];
    end
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_vlane
    sgb_lane u_lane (
      .clk (clk),
      .en  (b_move),
      .tap (vtap[k]),
      .q   (vq[k*CH_W +: CH_W])
    );
  end

  // Stage C: only jobs that produce a pixel go on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (c_open) begin
      c_vld_r <= b_vld_r && b_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_ctl_r    <= b_ctl_r;
      c_direct_r <= rd_q[b_ctl_r.rd_slot];
    end
  end

  // Merge: filtered lanes or the stored horizontal-only row
  assign v = c_ctl_r.vf ? vq : c_direct_r;

  always_comb begin
    out_nxt.out_blue  = v[0 +: CH_W];
    out_nxt.out_green = v[CH_W +: CH_W];
    out_nxt.out_red   = v[2*CH_W +: CH_W];
    out_nxt.frame_end = c_ctl_r.fin;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ld) begin
      out_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && c_vld_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // A pixel held back by the output stays in stage C
  a_c_hold: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld_r && !out_ld |=> c_vld_r)
    else $error("stage C pixel lost during output stall");

  // A stalled stage B job keeps its horizontal value
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && !c_open |=> b_vld_r && $stable(b_t_r))
    else $error("stage B job changed during stall");

  // The frame-end pixel comes from a flush read, which never writes or filters
  a_fin_flush: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld && a_ctl.fin |-> !a_ctl.wr && !a_ctl.vf && a_ctl.emit)
    else $error("frame end marked on a pixel job");

endmodule
